FILE: rtl/ase_pkg.sv
package ase_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_RD,
      ST_SORT_FIRST,
      ST_SORT_CMP,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_OUT_RD,
      ST_OUT_SHOW
   } state_type;

endpackage

FILE: rtl/array_sort_engine.sv
// Channel  Direction  Signals                                          Note
// req      in         req_valid, req_ready, req_value, req_is_final    one value per beat
// rsp      out        rsp_valid, rsp_ready, rsp_sorted_value,          one sorted value per beat
//                     rsp_end_of_run, rsp_overflow
// req_ready stays high while loading. The final beat starts a selection sort with one shared
// signed comparator reading one entry per cycle; each pass reads entry i, compares the rest
// and writes the minimum and entry i into each other's place when the two differ.
// Output then reads each entry before it shows it, and holds it while rsp_ready is low.
// Reset is synchronous and clears the sequencer, the fill count and the overflow flag.
// req_ready is low during the sort and output; a stalled rsp beat holds the sequencer.
module array_sort_engine #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   input  logic               req_is_final,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_end_of_run,
   output logic               rsp_overflow
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic signed [31:0] mem [CAPACITY];

   ase_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] min_ff, min_in;
   logic signed [31:0] minv_ff, minv_in;
   logic signed [31:0] ival_ff, ival_in;
   logic signed [31:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [31:0] wr_data;
   logic [CW-1:0] last_idx;
   logic          req_acc;

   assign req_acc  = req_valid && req_ready;
   assign last_idx = count_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ase_pkg::ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      min_ff  <= min_in;
      minv_ff <= minv_in;
      ival_ff <= ival_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ase_pkg::ST_LOAD: begin
            if (req_acc && req_is_final) begin
               state_in = ase_pkg::ST_SORT_RD;
            end
         end
         ase_pkg::ST_SORT_RD: begin
            if (CW'(i_ff) >= last_idx) begin
               state_in = ase_pkg::ST_OUT_RD;
            end else begin
               state_in = ase_pkg::ST_SORT_FIRST;
            end
         end
         ase_pkg::ST_SORT_FIRST: state_in = ase_pkg::ST_SORT_CMP;
         ase_pkg::ST_SORT_CMP: begin
            if (CW'(j_ff) == last_idx) begin
               state_in = ase_pkg::ST_SWAP_LO;
            end
         end
         ase_pkg::ST_SWAP_LO: begin
            if (min_ff != i_ff) begin
               state_in = ase_pkg::ST_SWAP_HI;
            end else begin
               state_in = ase_pkg::ST_SORT_RD;
            end
         end
         ase_pkg::ST_SWAP_HI: state_in = ase_pkg::ST_SORT_RD;
         ase_pkg::ST_OUT_RD: state_in = ase_pkg::ST_OUT_SHOW;
         ase_pkg::ST_OUT_SHOW: begin
            if (rsp_ready) begin
               if (CW'(i_ff) == last_idx) begin
                  state_in = ase_pkg::ST_LOAD;
               end else begin
                  state_in = ase_pkg::ST_OUT_RD;
               end
            end
         end
         default: state_in = ase_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      drop_in   = drop_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      min_in    = min_ff;
      minv_in   = minv_ff;
      ival_in   = ival_ff;
      rd_addr   = i_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = req_value;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ase_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            i_in      = '0;
            if (req_acc) begin
               if (count_ff < CAP) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         ase_pkg::ST_SORT_RD: begin
            rd_addr = i_ff;
            j_in    = i_ff + AW'(1);
            min_in  = i_ff;
            if (CW'(i_ff) >= last_idx) begin
               i_in = '0;
            end
         end
         ase_pkg::ST_SORT_FIRST: begin
            // rd_ff holds the entry at i, the first candidate of this pass.
            minv_in = rd_ff;
            ival_in = rd_ff;
            rd_addr = j_ff;
         end
         ase_pkg::ST_SORT_CMP: begin
            // rd_ff holds the entry at j; the next entry is read meanwhile.
            rd_addr = j_ff + AW'(1);
            j_in    = j_ff + AW'(1);
            if (rd_ff < minv_ff) begin
               minv_in = rd_ff;
               min_in  = j_ff;
            end
         end
         ase_pkg::ST_SWAP_LO: begin
            if (min_ff != i_ff) begin
               wr_en   = 1'b1;
               wr_addr = i_ff;
               wr_data = minv_ff;
            end else begin
               i_in = i_ff + AW'(1);
            end
         end
         ase_pkg::ST_SWAP_HI: begin
            wr_en   = 1'b1;
            wr_addr = min_ff;
            wr_data = ival_ff;
            i_in    = i_ff + AW'(1);
         end
         ase_pkg::ST_OUT_RD: begin
            rd_addr = i_ff;
         end
         ase_pkg::ST_OUT_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               i_in = i_ff + AW'(1);
               if (CW'(i_ff) == last_idx) begin
                  count_in = '0;
                  drop_in  = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_sorted_value = rd_ff;
   assign rsp_end_of_run   = (CW'(i_ff) == last_idx);
   assign rsp_overflow     = drop_ff;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int CAPACITY      = 64;
   localparam int STALL_LIMIT   = 20000;
   localparam int MAX_REPORTED  = 10;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_run;
      logic               overflow;
   } sorted_beat_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_value;
   logic               req_is_final;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_end_of_run;
   logic               rsp_overflow;

   array_sort_engine #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_is_final(req_is_final),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_sorted_value(rsp_sorted_value), .rsp_end_of_run(rsp_end_of_run),
      .rsp_overflow(rsp_overflow)
   );

   // Shadow copy of the set being loaded.
   logic signed [31:0] pending_values[$];
   logic               pending_dropped;
   sorted_beat_type    sorted_queue[$];

   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int idle_cycles;
   bit timed_out;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void load_value(logic signed [31:0] value, logic is_final);
      logic signed [31:0] key;
      int                 n;
      int                 j;
      if (pending_values.size() < CAPACITY) begin
         pending_values.push_back(value);
      end else begin
         pending_dropped = 1'b1;
      end
      if (is_final) begin
         n = pending_values.size();
         for (int i = 1; i < n; i++) begin
            key = pending_values[i];
            j = i;
            while (j > 0 && key < pending_values[j - 1]) begin
               pending_values[j] = pending_values[j - 1];
               j--;
            end
            pending_values[j] = key;
         end
         for (int k = 0; k < n; k++) begin
            sorted_queue.push_back('{pending_values[k], k == n - 1, pending_dropped});
         end
         pending_values.delete();
         pending_dropped = 1'b0;
      end
   endfunction

   task automatic send_value(logic signed [31:0] value, logic is_final);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid    = 1'b1;
      req_value    = value;
      req_is_final = is_final;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      load_value(value, is_final);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Receiver readiness, changed at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      sorted_beat_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("unexpected beat: value %0d end %0b overflow %0b",
                        rsp_sorted_value, rsp_end_of_run, rsp_overflow);
         end else begin
            expected = sorted_queue.pop_front();
            if (expected.sorted_value !== rsp_sorted_value ||
                expected.end_of_run !== rsp_end_of_run ||
                expected.overflow !== rsp_overflow) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                           expected.sorted_value, expected.end_of_run, expected.overflow,
                           rsp_sorted_value, rsp_end_of_run, rsp_overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return $signed(32'($urandom_range(7))) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic drain();
      while (sorted_queue.size() != 0) @(negedge clock);
   endtask

   task automatic send_set(int length);
      for (int i = 0; i < length; i++) send_value(random_value(), i == length - 1);
   endtask

   task automatic test_extremes();
      send_value(32'sh7fff_ffff, 1'b0);
      send_value(32'sh8000_0000, 1'b0);
      send_value(0, 1'b0);
      send_value(-1, 1'b0);
      send_value(32'sh5555_5555, 1'b0);
      send_value(32'shaaaa_aaaa, 1'b1);
      send_value(7, 1'b1);
      send_value(3, 1'b0);
      send_value(3, 1'b0);
      send_value(3, 1'b1);
      drain();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < CAPACITY; i++) send_value(random_value(), 1'b0);
      send_value(32'sh8000_0000, 1'b1);
      drain();
   endtask

   task automatic test_random_sets(int total);
      int sent;
      int length;
      sent = 0;
      while (sent < total) begin
         length = $urandom_range(8, 1);
         send_set(length);
         sent += length;
      end
   endtask

   task automatic test_back_pressure();
      hold_off_cycles = 300;
      send_set(8);
      send_set(5);
      send_set(3);
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_is_final    = 1'b0;
      rsp_ready       = 1'b0;
      pending_dropped = 1'b0;
      mismatch_count  = 0;
      hold_off_cycles = 0;
      idle_cycles     = 0;
      timed_out       = 1'b0;
      send_idle_pct   = 15;
      recv_idle_pct   = 68;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_overflow();
      test_random_sets(6);
      drain();
      send_idle_pct = 68;
      recv_idle_pct = 15;
      test_random_sets(6);
      test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sets(6);
      drain();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
